// ===== src/kvbpe_pkg.sv =====
`default_nettype none
package kvbpe_pkg;

    // Fixed field widths (key lengths up to 63, counts up to 127)
    localparam int KLEN_W      = 6;
    localparam int CNT_W       = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = 2;
    localparam int PEND_W      = 3;
    localparam int HDR_BYTES   = 12;
    localparam int ENTRY_BYTES = 12;
    localparam int TRAIL_BYTES = 4;

    typedef enum logic [1:0] {
        FN_KEY    = 2'd0,
        FN_VALUE  = 2'd1,
        FN_FINISH = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CMD_BYTE = 3'b001,
        CMD_KEY  = 3'b010,
        CMD_FIN  = 3'b100
    } t_cmd_kind;

    // One queued job for the emitter
    typedef struct packed {
        t_cmd_kind           kind;
        logic [7:0]          data;
        logic                err;
        logic [KLEN_W-1:0]   shared;
        logic [KLEN_W-1:0]   key_len;
        logic [15:0]         vlen;
        logic                bank;
        logic [CNT_W-1:0]    groups;
        logic [CNT_W-1:0]    last_cnt;
        logic [31:0]         end_off;
    } t_cmd;

    // Pick byte k of a little-endian 32-bit word
    function automatic logic [7:0] le_byte(input logic [31:0] w, input logic [1:0] k);
        logic [31:0] s;
        s = w >> {k, 3'b000};
        return s[7:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/kvbpe_ram.sv =====
`default_nettype none
module kvbpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/kvbpe_queue.sv =====
`default_nettype none
module kvbpe_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire kvbpe_pkg::t_cmd i_cmd,
    output logic                 o_full,
    output logic                 o_valid,
    output kvbpe_pkg::t_cmd      o_cmd,
    input  wire logic            i_pop
);
    import kvbpe_pkg::*;

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QAW'(1);
            if (i_pop)  r_rp <= r_rp + QAW'(1);
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underflow");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> o_valid) else $error("pushed job not visible");
endmodule
`default_nettype wire

// ===== src/kvbpe_front.sv =====
`default_nettype none
module kvbpe_front #(
    parameter int GROUP_RECORDS = 16,
    parameter int MAX_KEY_LEN   = 32,
    parameter int MAX_RECORDS   = 64,
    parameter int KAW           = 5,
    parameter int GAW           = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [1:0]            i_func,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_byte_last,
    input  wire logic [15:0]           i_value_length,
    output logic                       o_push,
    output kvbpe_pkg::t_cmd            o_cmd,
    input  wire logic                  i_full,
    input  wire logic                  i_back_done,
    output logic                       o_busy,
    output logic                       o_key_we,
    output logic                       o_key_wbank,
    output logic [KAW-1:0]             o_key_waddr,
    output logic [7:0]                 o_key_wdata,
    output logic [KAW-1:0]             o_key_raddr,
    input  wire logic [1:0][7:0]       i_key_rdata,
    output logic                       o_off_we,
    output logic [GAW-1:0]             o_off_waddr,
    output logic [31:0]                o_off_wdata
);
    import kvbpe_pkg::*;

    typedef enum logic [1:0] {
        FS_IDLE = 2'b01,
        FS_KEY  = 2'b10
    } t_fstate;

    t_fstate             r_state, n_state;
    logic [7:0]          r_byte;
    logic                r_last;
    logic [15:0]         r_vlen;
    logic [KLEN_W-1:0]   r_cur_len, n_cur_len;
    logic [KLEN_W-1:0]   r_prev_len, n_prev_len;
    logic [KLEN_W-1:0]   r_shared, n_shared;
    logic                r_broken, n_broken;
    logic                r_too_long, n_too_long;
    logic [CNT_W-1:0]    r_rc, n_rc;
    logic [CNT_W-1:0]    r_in_grp, n_in_grp;
    logic [CNT_W-1:0]    r_groups, n_groups;
    logic [31:0]         r_bb, n_bb;
    logic                r_vdrop, n_vdrop;
    logic                r_cur_bank, n_cur_bank;
    logic [PEND_W-1:0]   r_pend, n_pend;

    logic                accept;
    logic                k_ok, match;
    logic [KLEN_W-1:0]   k_len, k_sh, k_shr;
    logic                k_tl, k_br;
    logic [7:0]          prev_byte;

    assign o_busy      = (r_pend != '0);
    assign o_ready     = (r_state == FS_IDLE) && !i_full
                         && !((i_func == FN_KEY) && (r_pend != '0));
    assign accept      = i_valid && o_ready;
    assign o_key_raddr = r_cur_len[KAW-1:0];
    assign o_key_waddr = r_cur_len[KAW-1:0];
    assign o_key_wdata = r_byte;
    assign o_key_wbank = r_cur_bank;
    assign prev_byte   = i_key_rdata[~r_cur_bank];

    // Compare one key byte against the previous key
    always_comb begin
        k_ok  = (r_cur_len < KLEN_W'(MAX_KEY_LEN));
        match = !r_broken && (r_cur_len < r_prev_len) && (prev_byte == r_byte);
        k_tl  = r_too_long || !k_ok;
        k_sh  = (k_ok && match) ? r_shared + KLEN_W'(1) : r_shared;
        k_br  = k_ok ? (r_broken || !match) : r_broken;
        k_len = k_ok ? r_cur_len + KLEN_W'(1) : r_cur_len;
        k_shr = (r_in_grp == '0) ? '0 : k_sh;
    end

    // Classify items and keep block bookkeeping
    always_comb begin
        n_state    = r_state;
        n_cur_len  = r_cur_len;
        n_prev_len = r_prev_len;
        n_shared   = r_shared;
        n_broken   = r_broken;
        n_too_long = r_too_long;
        n_rc       = r_rc;
        n_in_grp   = r_in_grp;
        n_groups   = r_groups;
        n_bb       = r_bb;
        n_vdrop    = r_vdrop;
        n_cur_bank = r_cur_bank;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd.kind = CMD_BYTE;
        o_key_we   = 1'b0;
        o_off_we   = 1'b0;
        o_off_waddr = r_groups[GAW-1:0];
        o_off_wdata = r_bb;
        unique case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        FN_KEY: begin
                            n_state = FS_KEY;
                        end
                        FN_VALUE: begin
                            o_push = 1'b1;
                            o_cmd.kind = CMD_BYTE;
                            if (r_vdrop) begin
                                o_cmd.err = 1'b1;
                                if (i_byte_last) n_vdrop = 1'b0;
                            end else begin
                                o_cmd.data = i_data_byte;
                                n_bb = r_bb + 32'd1;
                            end
                        end
                        FN_FINISH: begin
                            o_push = 1'b1;
                            o_cmd.kind     = CMD_FIN;
                            o_cmd.groups   = r_groups;
                            o_cmd.last_cnt = (r_in_grp == '0) ? CNT_W'(GROUP_RECORDS)
                                                              : r_in_grp;
                            o_cmd.end_off  = r_bb;
                            n_bb = r_bb + {22'd0, r_groups, 3'd0} + {23'd0, r_groups, 2'd0}
                                   + 32'(TRAIL_BYTES);
                        end
                        default: begin
                            n_cur_len  = '0;
                            n_shared   = '0;
                            n_broken   = 1'b0;
                            n_too_long = 1'b0;
                            n_prev_len = '0;
                            n_rc       = '0;
                            n_in_grp   = '0;
                            n_groups   = '0;
                            n_bb       = '0;
                            n_vdrop    = 1'b0;
                        end
                    endcase
                end
            end
            FS_KEY: begin
                n_state  = FS_IDLE;
                n_vdrop  = 1'b0;
                o_key_we = k_ok;
                if (r_last) begin
                    n_cur_len  = '0;
                    n_shared   = '0;
                    n_broken   = 1'b0;
                    n_too_long = 1'b0;
                    o_push     = 1'b1;
                    if (k_tl || (r_rc >= CNT_W'(MAX_RECORDS))) begin
                        // Drop the record and flag it
                        o_cmd.kind = CMD_BYTE;
                        o_cmd.err  = 1'b1;
                        n_vdrop    = 1'b1;
                    end else begin
                        o_cmd.kind    = CMD_KEY;
                        o_cmd.shared  = k_shr;
                        o_cmd.key_len = k_len;
                        o_cmd.vlen    = r_vlen;
                        o_cmd.bank    = r_cur_bank;
                        if (r_in_grp == '0) begin
                            o_off_we = 1'b1;
                            n_groups = r_groups + CNT_W'(1);
                        end
                        n_in_grp   = (r_in_grp == CNT_W'(GROUP_RECORDS - 1)) ? '0
                                     : r_in_grp + CNT_W'(1);
                        n_cur_bank = ~r_cur_bank;
                        n_prev_len = k_len;
                        n_rc       = r_rc + CNT_W'(1);
                        n_bb       = r_bb + 32'(HDR_BYTES) + 32'(k_len) - 32'(k_shr);
                    end
                end else begin
                    n_cur_len  = k_len;
                    n_shared   = k_sh;
                    n_broken   = k_br;
                    n_too_long = k_tl;
                end
            end
            default: n_state = FS_IDLE;
        endcase
        n_pend = r_pend + PEND_W'(o_push && (o_cmd.kind != CMD_BYTE)) - PEND_W'(i_back_done);
    end

    // Hold the accepted byte, last flag and value length
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
            r_last <= i_byte_last;
            r_vlen <= i_value_length;
        end
    end

    // Update state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FS_IDLE;
            r_cur_len  <= '0;
            r_prev_len <= '0;
            r_shared   <= '0;
            r_broken   <= 1'b0;
            r_too_long <= 1'b0;
            r_rc       <= '0;
            r_in_grp   <= '0;
            r_groups   <= '0;
            r_bb       <= '0;
            r_vdrop    <= 1'b0;
            r_cur_bank <= 1'b0;
            r_pend     <= '0;
        end else begin
            r_state    <= n_state;
            r_cur_len  <= n_cur_len;
            r_prev_len <= n_prev_len;
            r_shared   <= n_shared;
            r_broken   <= n_broken;
            r_too_long <= n_too_long;
            r_rc       <= n_rc;
            r_in_grp   <= n_in_grp;
            r_groups   <= n_groups;
            r_bb       <= n_bb;
            r_vdrop    <= n_vdrop;
            r_cur_bank <= n_cur_bank;
            r_pend     <= n_pend;
        end
    end

    a_key_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_KEY) |-> (r_pend == '0)) else $error("key byte with emitter busy");
    a_done_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_back_done |-> (r_pend != '0)) else $error("done without pending job");
    a_key_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_KEY) |=> (r_state == FS_IDLE)) else $error("key step stuck");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full) else $error("push into full queue");
endmodule
`default_nettype wire

// ===== src/kvbpe_back.sv =====
`default_nettype none
module kvbpe_back #(
    parameter int GROUP_RECORDS = 16,
    parameter int KAW           = 5,
    parameter int GAW           = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire kvbpe_pkg::t_cmd i_cmd,
    output logic                 o_pop,
    output logic [KAW-1:0]       o_key_raddr,
    input  wire logic [1:0][7:0] i_key_rdata,
    output logic [GAW-1:0]       o_off_raddr,
    input  wire logic [31:0]     i_off_rdata,
    output logic                 o_done,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_run_last,
    output logic                 o_error
);
    import kvbpe_pkg::*;

    typedef enum logic [8:0] {
        BS_IDLE = 9'b000000001,
        BS_HDR  = 9'b000000010,
        BS_KEY  = 9'b000000100,
        BS_FA   = 9'b000001000,
        BS_FB   = 9'b000010000,
        BS_FW   = 9'b000100000,
        BS_FC   = 9'b001000000,
        BS_FENT = 9'b010000000,
        BS_FCNT = 9'b100000000
    } t_bstate;

    t_bstate           r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [3:0]        r_bcnt, n_bcnt;
    logic [KLEN_W-1:0] r_kidx, n_kidx;
    logic [CNT_W-1:0]  r_gi, n_gi;
    logic [CNT_W-1:0]  r_gaddr, n_gaddr;
    logic [31:0]       r_cur, n_cur;
    logic [31:0]       r_nxt, n_nxt;
    logic              r_ovalid;
    logic [7:0]        r_obyte;
    logic              r_olast, r_oerr;

    logic              out_free, emit, e_last, e_err;
    logic [7:0]        e_byte;
    logic [31:0]       word;
    logic [KLEN_W-1:0] unshared;
    logic              more_grp;

    assign out_free    = !r_ovalid || i_ready;
    assign o_key_raddr = n_kidx[KAW-1:0];
    assign o_off_raddr = r_gaddr[GAW-1:0];
    assign unshared    = r_cmd.key_len - r_cmd.shared;
    assign more_grp    = ({1'b0, r_gi} + 8'd1) < {1'b0, r_cmd.groups};
    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_run_last  = r_olast;
    assign o_error     = r_oerr;

    // Sequence the bytes of each job
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_bcnt  = r_bcnt;
        n_kidx  = r_kidx;
        n_gi    = r_gi;
        n_gaddr = r_gaddr;
        n_cur   = r_cur;
        n_nxt   = r_nxt;
        o_pop   = 1'b0;
        o_done  = 1'b0;
        emit    = 1'b0;
        e_byte  = '0;
        e_last  = 1'b0;
        e_err   = 1'b0;
        word    = '0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    if (i_cmd.kind == CMD_BYTE) begin
                        if (out_free) begin
                            o_pop  = 1'b1;
                            emit   = 1'b1;
                            e_byte = i_cmd.data;
                            e_err  = i_cmd.err;
                            e_last = 1'b1;
                        end
                    end else begin
                        o_pop  = 1'b1;
                        n_cmd  = i_cmd;
                        n_bcnt = '0;
                        n_gi   = '0;
                        n_gaddr = '0;
                        n_kidx = i_cmd.shared;
                        if (i_cmd.kind == CMD_KEY) begin
                            n_state = BS_HDR;
                        end else if (i_cmd.groups == '0) begin
                            n_state = BS_FCNT;
                        end else begin
                            n_state = BS_FA;
                        end
                    end
                end
            end
            BS_HDR: begin
                unique case (r_bcnt[3:2])
                    2'd0:    word = {26'd0, r_cmd.shared};
                    2'd1:    word = {26'd0, unshared};
                    default: word = {16'd0, r_cmd.vlen};
                endcase
                e_byte = le_byte(word, r_bcnt[1:0]);
                if (out_free) begin
                    emit   = 1'b1;
                    e_last = (r_bcnt == 4'(HDR_BYTES - 1)) && (unshared == '0);
                    if (r_bcnt == 4'(HDR_BYTES - 1)) begin
                        n_bcnt = '0;
                        if (unshared == '0) begin
                            o_done  = 1'b1;
                            n_state = BS_IDLE;
                        end else begin
                            n_state = BS_KEY;
                        end
                    end else begin
                        n_bcnt = r_bcnt + 4'd1;
                    end
                end
            end
            BS_KEY: begin
                e_byte = i_key_rdata[r_cmd.bank];
                if (out_free) begin
                    emit   = 1'b1;
                    n_kidx = r_kidx + KLEN_W'(1);
                    e_last = (n_kidx == r_cmd.key_len);
                    if (e_last) begin
                        o_done  = 1'b1;
                        n_state = BS_IDLE;
                    end
                end
            end
            BS_FA: begin
                n_state = BS_FB;
            end
            BS_FB: begin
                n_cur   = i_off_rdata;
                n_gaddr = r_gi + CNT_W'(1);
                n_state = BS_FW;
            end
            BS_FW: begin
                n_state = BS_FC;
            end
            BS_FC: begin
                n_nxt   = more_grp ? i_off_rdata : r_cmd.end_off;
                n_bcnt  = '0;
                n_state = BS_FENT;
            end
            BS_FENT: begin
                unique case (r_bcnt[3:2])
                    2'd0:    word = more_grp ? 32'(GROUP_RECORDS)
                                             : {25'd0, r_cmd.last_cnt};
                    2'd1:    word = r_nxt - r_cur;
                    default: word = r_cur;
                endcase
                e_byte = le_byte(word, r_bcnt[1:0]);
                if (out_free) begin
                    emit = 1'b1;
                    if (r_bcnt == 4'(ENTRY_BYTES - 1)) begin
                        n_bcnt = '0;
                        n_cur  = r_nxt;
                        n_gi   = r_gi + CNT_W'(1);
                        if (more_grp) begin
                            n_gaddr = r_gi + CNT_W'(2);
                            n_state = BS_FW;
                        end else begin
                            n_state = BS_FCNT;
                        end
                    end else begin
                        n_bcnt = r_bcnt + 4'd1;
                    end
                end
            end
            BS_FCNT: begin
                word   = {25'd0, r_cmd.groups};
                e_byte = le_byte(word, r_bcnt[1:0]);
                if (out_free) begin
                    emit = 1'b1;
                    if (r_bcnt == 4'(TRAIL_BYTES - 1)) begin
                        e_last  = 1'b1;
                        o_done  = 1'b1;
                        n_bcnt  = '0;
                        n_state = BS_IDLE;
                    end else begin
                        n_bcnt = r_bcnt + 4'd1;
                    end
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // Hold job context
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_bcnt  <= n_bcnt;
        r_kidx  <= n_kidx;
        r_gi    <= n_gi;
        r_gaddr <= n_gaddr;
        r_cur   <= n_cur;
        r_nxt   <= n_nxt;
        if (emit) begin
            r_obyte <= e_byte;
            r_olast <= e_last;
            r_oerr  <= e_err;
        end
    end

    // Control state and output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free) else $error("beat overwritten");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_ovalid && r_olast)) else $error("job ended without last beat");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == BS_IDLE)) else $error("pop while busy");
endmodule
`default_nettype wire

// ===== src/kv_block_prefix_encoder.sv =====
// Key-value block encoder with prefix compression and restart groups.
// Input channel (i_valid/o_ready): func selects key byte, value byte,
// finish or clear; a key's last byte carries the value length.
// Output channel (o_valid/i_ready): one encoded block byte per beat, with
// o_run_last on the final beat caused by an input item and o_error on the
// single beat returned for a dropped key or dropped value byte.
// A key byte gets a prefix RAM read then a compare in the front; value,
// finish and clear items are handled as accepted. A key byte is held off
// while a key record or finish is still being emitted, since those read
// the key and group offset RAMs. Value bytes stream at one per cycle,
// unless stalled, through a 4-entry job queue. A key record emits 12 +
// unshared bytes, one per cycle unless stalled; a finish emits 12 bytes
// per group plus 4, with offset RAM reads in FA, FB, FW, FC before the
// first group and in FW, FC before each later one. A stalled receiver
// holds the output register; the queue keeps accepting value bytes
// until it fills. Reset (and a clear item) empties the block.
`default_nettype none
module kv_block_prefix_encoder #(
    parameter int GROUP_RECORDS = 16,
    parameter int MAX_KEY_LEN   = 32,
    parameter int MAX_RECORDS   = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_last,
    input  wire logic [15:0] i_value_length,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_error
);
    import kvbpe_pkg::*;

    localparam int KAW  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int NGRP = (MAX_RECORDS + GROUP_RECORDS - 1) / GROUP_RECORDS;
    localparam int GAW  = (NGRP > 1) ? $clog2(NGRP) : 1;

    t_cmd             f_cmd, q_cmd;
    logic             f_push, q_full, q_valid, b_pop, b_done, f_busy;
    logic             k_we, k_wbank;
    logic [KAW-1:0]   k_waddr, f_raddr, b_raddr, k_raddr;
    logic [7:0]       k_wdata;
    logic [1:0][7:0]  k_rdata;
    logic             g_we;
    logic [GAW-1:0]   g_waddr, g_raddr;
    logic [31:0]      g_wdata, g_rdata;

    // Key RAM read port belongs to the emitter while a job is pending
    assign k_raddr = f_busy ? b_raddr : f_raddr;

    kvbpe_front #(
        .GROUP_RECORDS (GROUP_RECORDS),
        .MAX_KEY_LEN   (MAX_KEY_LEN),
        .MAX_RECORDS   (MAX_RECORDS),
        .KAW           (KAW),
        .GAW           (GAW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_byte_last    (i_byte_last),
        .i_value_length (i_value_length),
        .o_push         (f_push),
        .o_cmd          (f_cmd),
        .i_full         (q_full),
        .i_back_done    (b_done),
        .o_busy         (f_busy),
        .o_key_we       (k_we),
        .o_key_wbank    (k_wbank),
        .o_key_waddr    (k_waddr),
        .o_key_wdata    (k_wdata),
        .o_key_raddr    (f_raddr),
        .i_key_rdata    (k_rdata),
        .o_off_we       (g_we),
        .o_off_waddr    (g_waddr),
        .o_off_wdata    (g_wdata)
    );

    // Two key banks: current key and previous key swap on each record
    for (genvar b = 0; b < 2; b++) begin : g_bank
        kvbpe_ram #(
            .WIDTH (8),
            .DEPTH (MAX_KEY_LEN)
        ) u_key_ram (
            .i_clk   (i_clk),
            .i_we    (k_we && (k_wbank == 1'(b))),
            .i_waddr (k_waddr),
            .i_wdata (k_wdata),
            .i_raddr (k_raddr),
            .o_rdata (k_rdata[b])
        );
    end

    kvbpe_ram #(
        .WIDTH (32),
        .DEPTH (NGRP)
    ) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    kvbpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (b_pop)
    );

    kvbpe_back #(
        .GROUP_RECORDS (GROUP_RECORDS),
        .KAW           (KAW),
        .GAW           (GAW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (b_pop),
        .o_key_raddr (b_raddr),
        .i_key_rdata (k_rdata),
        .o_off_raddr (g_raddr),
        .i_off_rdata (g_rdata),
        .o_done      (b_done),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_error     (o_error)
    );
endmodule
`default_nettype wire
